// ===== rtl/isqrt_pkg.sv =====
// Shared widths and the per-cell item record for the integer square root.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package isqrt_pkg;

	// Radicand width; the root is computed exactly at this width.
	localparam int RADICAND_BITS = 32;
	// Width of the root field on the result channel.
	localparam int ROOT_FIELD_BITS = 16;
	// Full root width and the radicand padded to an even number of bits.
	localparam int ROOT_BITS = (RADICAND_BITS + 1) / 2;
	localparam int PAD_BITS = 2 * ROOT_BITS;
	// One cell per root bit.
	localparam int STAGES = ROOT_BITS;
	// Partial remainder width, wide enough for the shifted remainder.
	localparam int REM_BITS = ROOT_BITS + 3;

	// Item state handed from one cell to the next.
	typedef struct packed {
		logic [REM_BITS-1:0]  rem;
		logic [ROOT_BITS-1:0] root;
		logic [PAD_BITS-1:0]  rad;
	} cell_data_t;

endpackage

`default_nettype wire

// ===== rtl/isqrt_if.sv =====
// Valid/ready channel interfaces for radicand items and root items.
// Depends on isqrt_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface isqrt_in_if;
	import isqrt_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [RADICAND_BITS-1:0] radicand;

	modport source (output valid, output radicand, input ready);
	modport sink (input valid, input radicand, output ready);
endinterface

interface isqrt_out_if;
	import isqrt_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [ROOT_FIELD_BITS-1:0] root;

	modport source (output valid, output root, input ready);
	modport sink (input valid, input root, output ready);
endinterface

`default_nettype wire

// ===== rtl/integer_square_root.sv =====
// Top level of the integer square root: a chain of root cells between two channels.
// Depends on isqrt_pkg, isqrt_if and isqrt_cell.
//
//  channel      dir  payload              handshake
//  radicand_ch  in   radicand [31:0]      valid/ready
//  root_ch      out  root     [15:0]      valid/ready
//
// Each item passes through the 16 cells (one per root bit), each a register, before its
// result appears; one item enters per cycle unless a stalled output has filled the chain.
// Reset clears only the cell valid bits; no clearing pass.
// A stalled result holds the last cell; earlier cells keep filling until the
// chain is full, and only then does radicand_ch.ready drop.
`timescale 1ns / 1ps
`default_nettype none

module integer_square_root (
	input  wire        clk,
	input  wire        arst_n,
	isqrt_in_if.sink   radicand_ch,
	isqrt_out_if.source root_ch
);
	import isqrt_pkg::*;

	logic [STAGES:0] vld;
	logic [STAGES:0] rdy;
	cell_data_t      dat [STAGES+1];

	// Seed the chain with an empty remainder and root
	assign vld[0]      = radicand_ch.valid;
	assign radicand_ch.ready = rdy[0];
	assign dat[0].rem  = '0;
	assign dat[0].root = '0;
	assign dat[0].rad  = PAD_BITS'(radicand_ch.radicand);

	// One cell per root bit
	for (genvar i = 0; i < STAGES; i++) begin : g_cell
		isqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (vld[i]),
			.up_ready (rdy[i]),
			.up_data  (dat[i]),
			.dn_valid (vld[i+1]),
			.dn_ready (rdy[i+1]),
			.dn_data  (dat[i+1])
		);
	end

	// Last cell doubles as the output register
	assign root_ch.valid = vld[STAGES];
	assign rdy[STAGES]   = root_ch.ready;
	assign root_ch.root  = ROOT_FIELD_BITS'(dat[STAGES].root);

	// A taker on the output frees the whole chain in the same cycle
	a_ready_flows: assert property (@(posedge clk) disable iff (!arst_n)
		root_ch.ready |-> radicand_ch.ready)
		else $error("chain blocks input while output is taken");

	// Input stops only when every cell holds an item and the output stalls
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		!radicand_ch.ready |-> ($countones(vld[STAGES:1]) == STAGES) && !root_ch.ready)
		else $error("input refused with room in the chain");

	// A finished item has used every radicand pair and a bounded remainder
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld[STAGES] |-> (dat[STAGES].rad == '0) &&
			(dat[STAGES].rem <= REM_BITS'({dat[STAGES].root, 1'b0})))
		else $error("finished item has a bad remainder");
endmodule

`default_nettype wire

// ===== rtl/isqrt_cell.sv =====
// One cell of the root chain: settles one root bit from the next radicand pair.
// Depends on isqrt_pkg for cell_data_t and the widths.
`timescale 1ns / 1ps
`default_nettype none

module isqrt_cell (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     up_valid,
	output logic                    up_ready,
	input  wire isqrt_pkg::cell_data_t up_data,
	output logic                    dn_valid,
	input  wire                     dn_ready,
	output isqrt_pkg::cell_data_t   dn_data
);
	import isqrt_pkg::*;

	logic                 valid_q;
	cell_data_t           data_q;
	logic [REM_BITS-1:0]  rem_sh;
	logic [REM_BITS-1:0]  trial;
	logic                 take_bit;
	cell_data_t           data_nxt;

	// Shift in the next radicand pair and try the candidate bit
	always_comb begin
		rem_sh   = {up_data.rem[REM_BITS-3:0], up_data.rad[PAD_BITS-1 -: 2]};
		trial    = REM_BITS'({up_data.root, 2'b01});
		take_bit = (rem_sh >= trial);
		data_nxt.rem  = take_bit ? (rem_sh - trial) : rem_sh;
		data_nxt.root = ROOT_BITS'({up_data.root, take_bit});
		data_nxt.rad  = up_data.rad << 2;
	end

	// Accept when empty or when the held item moves on
	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	// Load the payload only on a real handoff
	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= data_nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;
endmodule

`default_nettype wire

// ===== dv/integer_square_root_test.sv =====
// Self-checking testbench for the integer square root block over its two valid/ready channels.
// Depends on isqrt_pkg, isqrt_if and the integer_square_root top level.
`timescale 1ns / 1ps

module integer_square_root_test;
	import isqrt_pkg::*;

	// Radicand sent and the root that must come back for it
	typedef struct packed {
		logic [RADICAND_BITS-1:0]   radicand;
		logic [ROOT_FIELD_BITS-1:0] root;
	} root_entry_t;

	// Directed stimulus row; root is only meaningful where known is set
	typedef struct packed {
		logic [RADICAND_BITS-1:0]   radicand;
		logic                       known;
		logic [ROOT_FIELD_BITS-1:0] root;
	} directed_row_t;

	localparam int DIRECTED_COUNT = 20;
	localparam int RANDOM_COUNT = 800;
	localparam int HOLD_OFF_AT = 200;
	localparam int PAUSE_AT = 450;
	localparam int QUIET_FROM = 550;
	localparam int QUIET_TO = 680;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int IDLE_PERCENT = 6;
	localparam int DRAIN_CYCLES = 40;

	localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		'{32'd0,          1'b1, 16'd0},
		'{32'd1,          1'b1, 16'd1},
		'{32'd2,          1'b0, 16'd0},
		'{32'd3,          1'b1, 16'd1},
		'{32'd4,          1'b1, 16'd2},
		'{32'd15,         1'b0, 16'd0},
		'{32'd16,         1'b1, 16'd4},
		'{32'd24,         1'b0, 16'd0},
		'{32'd4294967295, 1'b1, 16'd65535},
		'{32'd4294836225, 1'b1, 16'd65535},
		'{32'd4294836224, 1'b1, 16'd65534},
		'{32'd4294705156, 1'b1, 16'd65534},
		'{32'd4294705155, 1'b0, 16'd0},
		'{32'd1073741824, 1'b1, 16'd32768},
		'{32'd1073741823, 1'b1, 16'd32767},
		'{32'h80000000,   1'b0, 16'd0},
		'{32'h55555555,   1'b0, 16'd0},
		'{32'hAAAAAAAA,   1'b0, 16'd0},
		'{32'h0000FFFF,   1'b0, 16'd0},
		'{32'hFFFF0000,   1'b0, 16'd0}
	};

	logic clk;
	logic arst_n;

	isqrt_in_if  radicand_ch ();
	isqrt_out_if root_ch ();

	integer_square_root dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.radicand_ch (radicand_ch.sink),
		.root_ch     (root_ch.source)
	);

	root_entry_t expected_roots [$];
	int          mismatch_count = 0;
	bit          quiet = 1'b0;
	bit          hold_off_request = 1'b0;

	// Floor square root, restoring two radicand bits per step
	function automatic logic [ROOT_FIELD_BITS-1:0] floor_sqrt(
		input logic [RADICAND_BITS-1:0] radicand
	);
		logic [63:0] value;
		logic [63:0] remainder;
		logic [63:0] partial;
		logic [63:0] weight;
		value = 64'(radicand);
		remainder = value;
		partial = '0;
		weight = 64'd1 << 62;
		while (weight > value)
			weight = weight >> 2;
		while (weight != 0) begin
			if (remainder >= partial + weight) begin
				remainder = remainder - (partial + weight);
				partial = (partial >> 1) + weight;
			end else begin
				partial = partial >> 1;
			end
			weight = weight >> 2;
		end
		return partial[ROOT_FIELD_BITS-1:0];
	endfunction

	// Offer one radicand and hold it until taken; queue its root
	task automatic offer_radicand(
		input logic [RADICAND_BITS-1:0]   radicand,
		input logic                       known,
		input logic [ROOT_FIELD_BITS-1:0] known_root
	);
		root_entry_t entry;
		@(negedge clk);
		radicand_ch.valid <= 1'b1;
		radicand_ch.radicand <= radicand;
		@(posedge clk);
		while (!radicand_ch.ready)
			@(posedge clk);
		entry.radicand = radicand;
		entry.root = known ? known_root : floor_sqrt(radicand);
		expected_roots.push_back(entry);
	endtask

	// Drop valid for a short random gap now and then, unless quiet is set
	task automatic sender_gap();
		if (!quiet && $urandom_range(99) < IDLE_PERCENT) begin
			@(negedge clk);
			radicand_ch.valid <= 1'b0;
			repeat ($urandom_range(4)) @(negedge clk);
		end
	endtask

	// Stop offering and wait until every queued root has come back
	task automatic wait_for_roots();
		@(negedge clk);
		radicand_ch.valid <= 1'b0;
		while (expected_roots.size() != 0)
			@(posedge clk);
	endtask

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit on run length
	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

	// Result side: random back-pressure, one long hold-off, check each root
	initial begin
		root_entry_t entry;
		int          hold_left;
		hold_left = 0;
		root_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				root_ch.ready <= 1'b0;
			end else begin
				root_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PERCENT);
			end
			@(posedge clk);
			if (root_ch.valid && root_ch.ready) begin
				if (expected_roots.size() == 0) begin
					$display("%0t: root %0d arrived with no radicand outstanding",
						$time, root_ch.root);
					mismatch_count++;
				end else begin
					entry = expected_roots.pop_front();
					if (root_ch.root !== entry.root) begin
						$display("%0t: root of %0d: expected %0d, actual %0d",
							$time, entry.radicand, entry.root, root_ch.root);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Stimulus: reset, directed table, then random radicands
	initial begin
		logic [RADICAND_BITS-1:0]   radicand;
		logic [ROOT_FIELD_BITS-1:0] base;
		radicand_ch.valid <= 1'b0;
		radicand_ch.radicand <= '0;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Walk the directed table
		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			offer_radicand(DIRECTED_ROWS[i].radicand, DIRECTED_ROWS[i].known,
				DIRECTED_ROWS[i].root);
			sender_gap();
		end

		// Random radicands, weighted toward perfect squares and the edges
		for (int i = 0; i < RANDOM_COUNT; i++) begin
			if (i == HOLD_OFF_AT)
				hold_off_request = 1'b1;
			if (i == PAUSE_AT)
				wait_for_roots();
			quiet = (i >= QUIET_FROM) && (i < QUIET_TO);
			base = 16'($urandom);
			case ($urandom_range(9))
				3, 4: begin
					radicand = 32'(base) * 32'(base);
					case ($urandom_range(3))
						0: radicand = radicand - 32'd1;
						1: radicand = radicand + 32'd1;
						2: radicand = radicand + 32'(base) + 32'(base);
						default: ;
					endcase
				end
				5: radicand = 32'($urandom_range(1023));
				6: radicand = {16'hFFFF, base};
				7: radicand = $urandom >> $urandom_range(31);
				default: radicand = $urandom;
			endcase
			offer_radicand(radicand, 1'b0, '0);
			sender_gap();
		end
		quiet = 1'b0;

		// Drain, then watch for stray results
		wait_for_roots();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_roots.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
